// ----- src/range_to_pulsed_vibration_drive_assert.svh -----
// ----------------------------------------------------------------------------
// range to pulsed vibration drive assertion macros
// property wrappers clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef RANGE_TO_PULSED_VIBRATION_DRIVE_ASSERT_SVH
`define RANGE_TO_PULSED_VIBRATION_DRIVE_ASSERT_SVH

// same-cycle implication
`define RPVD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RPVD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rpvd_pkg.sv -----
// ----------------------------------------------------------------------------
// rpvd_pkg
// shared widths, constants, register indexes and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package rpvd_pkg;

	localparam int RangeW   = 16;
	localparam int DutyW    = 8;
	localparam int PowerW   = 4;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam int CntW     = $clog2(RangeW);
	localparam int LaneCnt  = 2;
	localparam int SpanW    = PowerW + DutyW;

	localparam int MaxDuty   = 255;
	localparam int NumLevels = 10;
	// drive span per strength step
	localparam int DutyStep  = MaxDuty / 10;
	// lowest nonzero level the drive can show
	localparam int DutyFloor = MaxDuty - NumLevels * DutyStep;

	localparam int LanePeriod = 0;
	localparam int LaneDuty   = 1;

	localparam logic [CfgIdxW-1:0] RegPower     = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] RegMinPeriod = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] RegMaxPeriod = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] RegRangeLow  = CfgIdxW'(3);
	localparam logic [CfgIdxW-1:0] RegRangeHigh = CfgIdxW'(4);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} rpvd_state_t;

endpackage

`default_nettype wire

// ----- src/range_to_pulsed_vibration_drive.sv -----
// ----------------------------------------------------------------------------
// range to pulsed vibration drive
// One tick transaction in, one result transaction out. A tick that does not
// reach the pulse period, or that reaches it with an invalid range, is
// answered in the next cycle. A tick that runs the step with a valid range
// holds off the next tick while it steps through clamping the sample, forming
// the differences, a bit-serial shift-add multiply, a restoring divide one
// quotient bit per cycle, and a commit that waits for a free output. The period
// and duty mappings run side by side in two lanes of the multiply and divide.
// ----------------------------------------------------------------------------
`default_nettype none

module range_to_pulsed_vibration_drive import rpvd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                tick_valid,
	output logic                tick_stall,
	input  logic [RangeW-1:0]   range_sample,
	input  logic                range_valid,
	output logic                drive_valid,
	input  logic                drive_stall,
	output logic [DutyW-1:0]    duty,
	output logic                duty_updated,
	output logic [RangeW-1:0]   period_now
);

	// configuration
	logic [PowerW-1:0] power_level_q;
	logic [RangeW-1:0] min_period_q;
	logic [RangeW-1:0] max_period_q;
	logic [RangeW-1:0] range_low_q;
	logic [RangeW-1:0] range_high_q;

	// drive state
	logic [RangeW-1:0] elapsed_q;
	logic [RangeW-1:0] period_q;
	logic              off_q;
	logic [DutyW-1:0]  duty_q;

	// output register
	logic              out_valid_q;
	logic [DutyW-1:0]  out_duty_q;
	logic              out_updated_q;
	logic [RangeW-1:0] out_period_q;

	// serial datapath
	rpvd_state_t         state_q, state_d;
	logic [CntW-1:0]     cnt_q;
	logic [RangeW-1:0]   x_q;
	logic [RangeW-1:0]   acand_q;
	logic [RangeW-1:0]   den_q;
	logic                den_zero_q;
	logic                neg_q;
	logic [2*RangeW-1:0] work_q [LaneCnt];
	logic [2*RangeW-1:0] mul_next [LaneCnt];
	logic [2*RangeW-1:0] div_next [LaneCnt];
	logic [RangeW:0]     mul_sum [LaneCnt];
	logic [RangeW:0]     div_t [LaneCnt];
	logic [RangeW:0]     div_diff [LaneCnt];
	logic                div_ge [LaneCnt];

	logic              tick_acc;
	logic              out_free;
	logic              out_load;
	logic              commit;
	logic [RangeW-1:0] elapsed_inc;
	logic              step_run;
	logic              start_map;
	logic              cnt_last;
	logic              lt_low, lt_high, low_lt_high;
	logic [RangeW-1:0] x_clamped;
	logic [RangeW-1:0] diff_x;
	logic [RangeW-1:0] diff_den;
	logic [RangeW-1:0] diff_per;
	logic [SpanW-1:0]  span_full;
	logic [RangeW-1:0] q_per;
	logic [DutyW-1:0]  q_duty;
	logic [RangeW-1:0] per_new;
	logic [DutyW-1:0]  level_new;
	logic [DutyW-1:0]  duty_new;

	assign out_free  = !out_valid_q || !drive_stall;
	assign tick_stall = (state_q != ST_IDLE) || !out_free;
	assign tick_acc  = tick_valid && !tick_stall;

	assign elapsed_inc = (elapsed_q == {RangeW{1'b1}}) ? elapsed_q : elapsed_q + RangeW'(1);
	assign step_run    = elapsed_inc >= period_q;
	assign start_map   = tick_acc && step_run && range_valid;
	assign cnt_last    = cnt_q == CntW'(RangeW - 1);

	// clamp as median of sample and both window ends
	assign lt_low      = x_q < range_low_q;
	assign lt_high     = x_q < range_high_q;
	assign low_lt_high = range_low_q < range_high_q;
	always_comb begin
		if (lt_low && lt_high) begin
			x_clamped = low_lt_high ? range_low_q : range_high_q;
		end else if (!lt_low && !lt_high) begin
			x_clamped = low_lt_high ? range_high_q : range_low_q;
		end else begin
			x_clamped = x_q;
		end
	end

	assign diff_x   = (x_q >= range_low_q) ? x_q - range_low_q : range_low_q - x_q;
	assign diff_den = (range_high_q >= range_low_q) ? range_high_q - range_low_q
		: range_low_q - range_high_q;
	assign diff_per = (max_period_q >= min_period_q) ? max_period_q - min_period_q
		: min_period_q - max_period_q;
	assign span_full = {{DutyW{1'b0}}, power_level_q} * SpanW'(DutyStep);

	// shift-add multiply and restoring divide, one bit per cycle per lane
	always_comb begin
		for (int i = 0; i < LaneCnt; i++) begin
			mul_sum[i]  = {1'b0, work_q[i][2*RangeW-1:RangeW]}
				+ (work_q[i][0] ? {1'b0, acand_q} : {(RangeW+1){1'b0}});
			mul_next[i] = {mul_sum[i], work_q[i][RangeW-1:1]};
			div_t[i]    = {work_q[i][2*RangeW-1:RangeW], work_q[i][RangeW-1]};
			div_diff[i] = div_t[i] - {1'b0, den_q};
			div_ge[i]   = div_t[i] >= {1'b0, den_q};
			div_next[i] = {(div_ge[i] ? div_diff[i][RangeW-1:0] : div_t[i][RangeW-1:0]),
				work_q[i][RangeW-2:0], div_ge[i]};
		end
	end

	assign q_per     = den_zero_q ? {RangeW{1'b0}} : work_q[LanePeriod][RangeW-1:0];
	assign q_duty    = den_zero_q ? {DutyW{1'b0}} : work_q[LaneDuty][DutyW-1:0];
	assign per_new   = neg_q ? min_period_q - q_per : min_period_q + q_per;
	assign level_new = DutyW'(MaxDuty) - q_duty;
	assign duty_new  = off_q ? level_new : {DutyW{1'b0}};

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		commit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start_map) begin
					state_d = ST_CLAMP;
				end else if (tick_acc) begin
					out_load = 1'b1;
				end
			end
			ST_CLAMP: state_d = ST_PREP;
			ST_PREP:  state_d = ST_MUL;
			ST_MUL: begin
				if (cnt_last) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					commit   = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_level_q <= PowerW'(10);
			min_period_q  <= RangeW'(100);
			max_period_q  <= RangeW'(1000);
			range_low_q   <= RangeW'(0);
			range_high_q  <= RangeW'(2000);
		end else if (cfg_we) begin
			case (cfg_index)
				RegPower: begin
					if (cfg_data[PowerW-1:0] <= PowerW'(NumLevels)) begin
						power_level_q <= cfg_data[PowerW-1:0];
					end
				end
				RegMinPeriod: min_period_q <= cfg_data[RangeW-1:0];
				RegMaxPeriod: max_period_q <= cfg_data[RangeW-1:0];
				RegRangeLow:  range_low_q  <= cfg_data[RangeW-1:0];
				RegRangeHigh: range_high_q <= cfg_data[RangeW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			period_q    <= RangeW'(1);
			off_q       <= 1'b0;
			duty_q      <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (tick_acc) begin
				elapsed_q <= step_run ? {RangeW{1'b0}} : elapsed_inc;
				if (step_run && !range_valid) begin
					duty_q   <= '0;
					period_q <= RangeW'(1);
				end
			end
			if (commit) begin
				period_q <= per_new;
				duty_q   <= duty_new;
				off_q    <= !off_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!drive_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_MUL || state_q == ST_DIV) begin
				cnt_q <= cnt_q + CntW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (start_map) begin
			x_q <= range_sample;
		end
		if (state_q == ST_CLAMP) begin
			x_q <= x_clamped;
		end
		if (state_q == ST_PREP) begin
			acand_q    <= diff_x;
			den_q      <= diff_den;
			den_zero_q <= range_low_q == range_high_q;
			neg_q      <= max_period_q < min_period_q;
			work_q[LanePeriod] <= {{RangeW{1'b0}}, diff_per};
			work_q[LaneDuty]   <= {{(2*RangeW-DutyW){1'b0}}, span_full[DutyW-1:0]};
		end
		for (int i = 0; i < LaneCnt; i++) begin
			if (state_q == ST_MUL) begin
				work_q[i] <= mul_next[i];
			end else if (state_q == ST_DIV) begin
				work_q[i] <= div_next[i];
			end
		end
		if (commit) begin
			out_duty_q    <= duty_new;
			out_updated_q <= 1'b1;
			out_period_q  <= per_new;
		end else if (out_load) begin
			out_updated_q <= step_run;
			if (step_run) begin
				out_duty_q   <= '0;
				out_period_q <= RangeW'(1);
			end else begin
				out_duty_q   <= duty_q;
				out_period_q <= period_q;
			end
		end
	end

	assign drive_valid  = out_valid_q;
	assign duty         = out_duty_q;
	assign duty_updated = out_updated_q;
	assign period_now   = out_period_q;

endmodule

`default_nettype wire

// ----- src/rpvd_checker.sv -----
// ----------------------------------------------------------------------------
// rpvd_checker
// port-level checks for the range to pulsed vibration drive
// ----------------------------------------------------------------------------
`default_nettype none

`include "range_to_pulsed_vibration_drive_assert.svh"

module rpvd_checker import rpvd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               tick_valid,
	input logic               tick_stall,
	input logic               drive_valid,
	input logic               drive_stall,
	input logic [DutyW-1:0]   duty,
	input logic               duty_updated,
	input logic [RangeW-1:0]  period_now
);

	// stalled result transaction holds
	`RPVD_ASSERT_NEXT(a_out_hold, drive_valid && drive_stall,
		drive_valid && $stable(duty) && $stable(duty_updated) && $stable(period_now),
		"stalled result changed")

	// a waiting result blocks the next tick
	`RPVD_ASSERT_NOW(a_backpressure, drive_valid && drive_stall, tick_stall,
		"tick taken while result stalled")

	// an accepted tick is either answered next cycle or keeps the block busy
	`RPVD_ASSERT_NEXT(a_tick_answer, tick_valid && !tick_stall, drive_valid || tick_stall,
		"tick neither answered nor in progress")

	// drive level is off or within the mapped span
	`RPVD_ASSERT_NOW(a_duty_range, drive_valid,
		duty == '0 || duty >= DutyW'(DutyFloor), "duty outside mapped span")

endmodule

bind range_to_pulsed_vibration_drive rpvd_checker u_rpvd_checker (.*);

`default_nettype wire
